### hw/rtl/slid_pkg.sv
// shared types and constants for the sorted list insert/delete unit
// no dependencies; used by slid_cell and sorted_list_insert_delete_unit
`default_nettype none

package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ENTRY_W  = 5;
   localparam int VALUE_W  = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [ENTRY_W-1:0]        entry_count;
      logic signed [VALUE_W-1:0] smallest_value;
   } rsp_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic signed [VALUE_W-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/sorted_list_insert_delete_unit.sv
// sorted list insert/delete unit: a chain of compare-and-shift cells
// result: registered, valid in the cycle after an item is accepted
// throughput: one item per cycle while results are taken, set by the compare and shift in every cell
// reset: entry count goes to zero, result register empties; cell values are not cleared
// depends on slid_pkg and slid_cell
`default_nettype none

module sorted_list_insert_delete_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire slid_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      slid_pkg::rsp_type rsp_payload
);

   localparam int N = slid_pkg::CAPACITY;

   logic [slid_pkg::COUNT_W-1:0] count_ff;
   logic [slid_pkg::COUNT_W-1:0] count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   slid_pkg::rsp_type            rsp_ff;
   slid_pkg::rsp_type            rsp_in;

   slid_pkg::cell_ctl_type ctl;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   found;
   slid_pkg::status_type   status;

   logic [N-1:0]                        occ_w;
   logic [N-1:0]                        after_w;
   logic [N-1:0]                        hit_w;
   logic signed [slid_pkg::VALUE_W-1:0] value_w [N];
   logic signed [slid_pkg::VALUE_W-1:0] next_w  [N];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == slid_pkg::COUNT_W'(N));
   assign empty = (count_ff == '0);
   assign found = |hit_w;

   always_comb begin
      ctl.key    = req_payload.value;
      ctl.ins_en = 1'b0;
      ctl.del_en = 1'b0;
      count_in   = count_ff;
      status     = slid_pkg::ST_OK;
      case (req_payload.op)
         slid_pkg::OP_INSERT: begin
            if (full) begin
               status = slid_pkg::ST_FULL;
            end else begin
               ctl.ins_en = accept;
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         slid_pkg::OP_DELETE: begin
            if (empty) begin
               status = slid_pkg::ST_EMPTY;
            end else if (!found) begin
               status = slid_pkg::ST_NOT_FOUND;
            end else begin
               ctl.del_en = accept;
               if (accept) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            status = slid_pkg::ST_OK;
         end
      endcase
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                                left_after;
      logic signed [slid_pkg::VALUE_W-1:0] left_value;
      logic signed [slid_pkg::VALUE_W-1:0] right_value;

      assign occ_w[i] = (slid_pkg::COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_after = 1'b0;
         assign left_value = '0;
      end else begin : g_inner
         assign left_after = after_w[i-1];
         assign left_value = value_w[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_body
         assign right_value = value_w[i+1];
      end

      slid_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occ         (occ_w[i]),
         .left_after  (left_after),
         .left_value  (left_value),
         .right_value (right_value),
         .after       (after_w[i]),
         .hit         (hit_w[i]),
         .value       (value_w[i]),
         .value_next  (next_w[i])
      );
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = status;
         rsp_in.entry_count    = slid_pkg::ENTRY_W'(count_in);
         rsp_in.smallest_value = (count_in == '0) ? '0 : next_w[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slid_pkg::COUNT_W'(N))
      else $error("entry count above capacity");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");

   a_empty_smallest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.entry_count == '0) |-> (rsp_payload.smallest_value == '0))
      else $error("empty store reported nonzero smallest value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == slid_pkg::ST_FULL)
         |-> (rsp_payload.entry_count == slid_pkg::ENTRY_W'(N)))
      else $error("full status with store not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && (status == slid_pkg::ST_OK) && (req_payload.op == slid_pkg::OP_INSERT)
         |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the store");

endmodule

`default_nettype wire

### hw/rtl/slid_cell.sv
// one slot of the sorted chain: holds a value, compares it with the key and
// takes its own, the key, or a neighbor's value; uses slid_pkg
`default_nettype none

module slid_cell (
   input  wire logic                                 clock,
   input  wire slid_pkg::cell_ctl_type               ctl,
   input  wire logic                                 occ,
   input  wire logic                                 left_after,
   input  wire logic signed [slid_pkg::VALUE_W-1:0]  left_value,
   input  wire logic signed [slid_pkg::VALUE_W-1:0]  right_value,
   output      logic                                 after,
   output      logic                                 hit,
   output      logic signed [slid_pkg::VALUE_W-1:0]  value,
   output      logic signed [slid_pkg::VALUE_W-1:0]  value_next
);

   logic signed [slid_pkg::VALUE_W-1:0] value_ff;
   logic signed [slid_pkg::VALUE_W-1:0] value_in;
   logic                                below;

   // after: slot sits past the insert point (empty or holds a larger value)
   assign after = !(occ && (value_ff <= ctl.key));
   assign below = occ && (value_ff < ctl.key);
   assign hit   = occ && (value_ff == ctl.key);

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (left_after) begin
            value_in = left_value;
         end else if (after) begin
            value_in = ctl.key;
         end
      end else if (ctl.del_en) begin
         // slots from the first match on pull from the right
         if (!below) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

`default_nettype wire

### verif/sorted_list_insert_delete_unit_tb.sv
// testbench for sorted_list_insert_delete_unit: directed and random insert/delete items,
// every result checked against an in-bench model of the sorted multiset store
// depends on slid_pkg and the sorted_list_insert_delete_unit rtl
`timescale 1ns / 100ps

class sorted_store_scoreboard;
   logic signed [slid_pkg::VALUE_W-1:0] contents[$];
   slid_pkg::rsp_type                   expected_q[$];
   int                                  failure_count;

   function new();
      failure_count = 0;
   endfunction

   function void report_failure(string what);
      failure_count++;
      if (failure_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endfunction

   // apply one accepted item to the store model and queue its result
   function void note_request(slid_pkg::req_type item);
      slid_pkg::rsp_type exp;
      int                pos;
      pos = 0;
      if (item.op == slid_pkg::OP_INSERT) begin
         if (contents.size() >= slid_pkg::CAPACITY) begin
            exp.status = slid_pkg::ST_FULL;
         end else begin
            while (pos < contents.size() && contents[pos] <= item.value) pos++;
            contents.insert(pos, item.value);
            exp.status = slid_pkg::ST_OK;
         end
      end else begin
         if (contents.size() == 0) begin
            exp.status = slid_pkg::ST_EMPTY;
         end else begin
            while (pos < contents.size() && contents[pos] != item.value) pos++;
            if (pos >= contents.size()) begin
               exp.status = slid_pkg::ST_NOT_FOUND;
            end else begin
               contents.delete(pos);
               exp.status = slid_pkg::ST_OK;
            end
         end
      end
      exp.entry_count    = slid_pkg::ENTRY_W'(contents.size());
      exp.smallest_value = (contents.size() > 0) ? contents[0] : '0;
      expected_q.push_back(exp);
   endfunction

   function void check_result(slid_pkg::rsp_type got);
      slid_pkg::rsp_type exp;
      if (expected_q.size() == 0) begin
         report_failure($sformatf("unexpected result status=%0d count=%0d smallest=%0d",
                                  got.status, got.entry_count, got.smallest_value));
      end else begin
         exp = expected_q.pop_front();
         if (got.status !== exp.status || got.entry_count !== exp.entry_count ||
             got.smallest_value !== exp.smallest_value) begin
            report_failure($sformatf(
               "expected status=%0d count=%0d smallest=%0d, got status=%0d count=%0d smallest=%0d",
               exp.status, exp.entry_count, exp.smallest_value,
               got.status, got.entry_count, got.smallest_value));
         end
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module sorted_list_insert_delete_unit_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 875;
   localparam int QUIET_ITEMS  = 100;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam logic signed [slid_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [slid_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   slid_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   slid_pkg::rsp_type rsp_payload;

   sorted_store_scoreboard sb;
   int  cycle_count;
   bit  hold_off;
   bit  no_idle;
   logic signed [slid_pkg::VALUE_W-1:0] inserted_pool[$];

   sorted_list_insert_delete_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_payload);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
      end
   end

   // result side: random stalls, one long hold-off on request, none at the end
   initial begin
      int n;
      rsp_ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic drive_item(input slid_pkg::op_type op,
                             input logic signed [slid_pkg::VALUE_W-1:0] value);
      slid_pkg::req_type item;
      item.op    = op;
      item.value = value;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (op == slid_pkg::OP_INSERT) begin
         inserted_pool.push_back(value);
         if (inserted_pool.size() > 32) void'(inserted_pool.pop_front());
      end
   endtask

   task automatic sender_gap();
      int n;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic signed [slid_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return $signed($urandom_range(0, 6)) - 3;
         3: begin
            case ($urandom_range(0, 4))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int  idx;
      bit  filling;
      bit  do_insert;
      logic signed [slid_pkg::VALUE_W-1:0] v;

      sb          = new();
      cycle_count = 0;
      hold_off    = 1'b0;
      no_idle     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty delete, extremes, duplicates, absent value, fill to full
      drive_item(slid_pkg::OP_DELETE, 0);
      drive_item(slid_pkg::OP_INSERT, VALUE_MAX);
      drive_item(slid_pkg::OP_INSERT, VALUE_MIN);
      drive_item(slid_pkg::OP_INSERT, 0);
      drive_item(slid_pkg::OP_INSERT, 0);
      drive_item(slid_pkg::OP_INSERT, -1);
      drive_item(slid_pkg::OP_DELETE, 12345);
      drive_item(slid_pkg::OP_DELETE, VALUE_MIN);
      drive_item(slid_pkg::OP_DELETE, 0);
      for (int k = 0; k < 13; k++) begin
         drive_item(slid_pkg::OP_INSERT, $signed(k * 37) - 200);
      end
      drive_item(slid_pkg::OP_INSERT, 7);
      drive_item(slid_pkg::OP_DELETE, VALUE_MAX);
      drive_item(slid_pkg::OP_DELETE, -1);

      // random: alternating fill and drain phases so the store hits full and empty
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) hold_off = 1'b1;
         if (i == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
         sender_gap();
         filling   = ((i / 40) % 2) == 0;
         do_insert = filling ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
         if (do_insert) begin
            drive_item(slid_pkg::OP_INSERT, pick_value());
         end else if (inserted_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, inserted_pool.size() - 1);
            v   = inserted_pool[idx];
            inserted_pool.delete(idx);
            drive_item(slid_pkg::OP_DELETE, v);
         end else begin
            drive_item(slid_pkg::OP_DELETE, pick_value());
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failure_count == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

### filelist.f
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/sorted_list_insert_delete_unit.sv
verif/sorted_list_insert_delete_unit_tb.sv
